/* rtl/core/aes_pkg.sv */
package aes_pkg;

  localparam int unsigned RoundsShort = 10;
  localparam int unsigned RoundsLong  = 14;
  localparam int unsigned KeyBytesShort = 16;
  localparam int unsigned KeyBytesLong  = 32;
  localparam int unsigned NkShort = KeyBytesShort / 4;
  localparam int unsigned NkLong  = KeyBytesLong / 4;
  localparam int unsigned NumWords = 4 * (RoundsLong + 1);
  localparam int unsigned WordIdxW = $clog2(NumWords + 1);
  localparam int unsigned NumStages = RoundsLong + 1;

  localparam logic [2:0] CFG_KEY_WORD_0 = 3'd0;
  localparam logic [2:0] CFG_KEY_WORD_1 = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD_2 = 3'd2;
  localparam logic [2:0] CFG_KEY_WORD_3 = 3'd3;
  localparam logic [2:0] CFG_KEY_LONG   = 3'd4;

  typedef enum logic [1:0] {
    KX_LOAD,
    KX_RUN,
    KX_DONE
  } kx_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic ready;
  } kx_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte 0 sits in the top bits
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic do_mix);
    logic [7:0] t [16];
    logic [7:0] m [16];
    logic [7:0] all;
    logic [127:0] res;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      for (int r = 0; r < 4; r++) begin
        m[4*c+r] = t[4*c+r] ^ all ^ xtime(t[4*c+r] ^ t[4*c+((r+1)%4)]);
      end
    end
    for (int i = 0; i < 16; i++) begin
      res[127-8*i -: 8] = (do_mix ? m[i] : t[i]) ^ k[127-8*i -: 8];
    end
    return res;
  endfunction

endpackage

/* rtl/core/aes_block_encrypt.sv */
// AES-128/256 forward cipher.
// in_*  : plaintext requests, accepted when in_tvalid && in_tready.
// out_* : ciphertext requests, one per input, in order.
// cfg_* : key register writes (index 0..3 key words, 4 key length); cfg_ready is
//         always high. Write only while no request is in flight.
// After reset or any key write the round keys are expanded by a one-word-a-cycle
// sequencer: a load state, then 40 (128-bit) or 52 (256-bit) words, during which
// in_tready is low.
// Datapath: 15 register stages (initial key add, then one round per stage; for
// 128-bit keys stages 11..14 pass the state through). Throughput is one block per
// cycle while the output is not stalled.
// When out_tready is low with a result waiting, the whole pipeline holds and
// in_tready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and restarts key expansion.
module aes_block_encrypt (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // plain_high[63:0], plain_low[127:64]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // cipher_high[63:0], cipher_low[127:64]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import aes_pkg::*;

  logic [63:0] key_word_r [4];
  logic        key_long_r;
  logic        cfg_hit;

  kx_state_t   kx_state_r, kx_state_nxt;
  kx_ctrl_t    kx;
  logic [31:0] win_r [8];
  logic [31:0] rk_r [NumWords];
  logic [WordIdxW-1:0] idx_r;
  logic [7:0]  rc_r;
  logic [WordIdxW-1:0] total;
  logic [31:0] prev_w, t_w, new_w, far_w;
  logic        nk_hit, nk_mid;

  logic [127:0] st_r [NumStages];
  logic         v_r [NumStages];
  logic         en;
  logic [127:0] plain;
  logic [3:0]   nr;

  assign cfg_ready = 1'b1;
  assign cfg_hit = cfg_valid && (cfg_index == CFG_KEY_WORD_0 || cfg_index == CFG_KEY_WORD_1 ||
                                 cfg_index == CFG_KEY_WORD_2 || cfg_index == CFG_KEY_WORD_3 ||
                                 cfg_index == CFG_KEY_LONG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 4; j++) key_word_r[j] <= '0;
      key_long_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEY_WORD_0: key_word_r[0] <= cfg_data;
        CFG_KEY_WORD_1: key_word_r[1] <= cfg_data;
        CFG_KEY_WORD_2: key_word_r[2] <= cfg_data;
        CFG_KEY_WORD_3: key_word_r[3] <= cfg_data;
        CFG_KEY_LONG:   key_long_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // key expansion sequencer
  assign total = key_long_r ? WordIdxW'(NumWords) : WordIdxW'(4 * (RoundsShort + 1));

  always_comb begin
    kx_state_nxt = kx_state_r;
    unique case (kx_state_r)
      KX_LOAD: kx_state_nxt = KX_RUN;
      KX_RUN:  if (idx_r == total - WordIdxW'(1)) kx_state_nxt = KX_DONE;
      KX_DONE: kx_state_nxt = KX_DONE;
      default: kx_state_nxt = KX_LOAD;
    endcase
    if (cfg_hit) kx_state_nxt = KX_LOAD;
  end

  always_comb begin
    kx = '0;
    unique case (kx_state_r)
      KX_LOAD: kx.load = 1'b1;
      KX_RUN:  kx.step = 1'b1;
      KX_DONE: kx.ready = 1'b1;
      default: kx = '0;
    endcase
  end

  assign prev_w = win_r[7];
  assign far_w  = key_long_r ? win_r[0] : win_r[4];
  assign nk_hit = key_long_r ? (idx_r[2:0] == 3'd0) : (idx_r[1:0] == 2'd0);
  assign nk_mid = key_long_r && (idx_r[2:0] == 3'd4);

  always_comb begin
    t_w = prev_w;
    priority if (nk_hit) t_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rc_r, 24'h0};
    else if (nk_mid)     t_w = sub_word(prev_w);
    else                 t_w = prev_w;
    new_w = far_w ^ t_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) kx_state_r <= KX_LOAD;
    else        kx_state_r <= kx_state_nxt;
  end

  always_ff @(posedge clk) begin
    if (kx.load) begin
      for (int j = 0; j < 8; j++) begin
        rk_r[j] <= (j % 2 == 1) ? key_word_r[j/2][31:0] : key_word_r[j/2][63:32];
      end
      for (int j = 0; j < 4; j++) begin
        win_r[j]   <= (j % 2 == 1) ? key_word_r[j/2][31:0] : key_word_r[j/2][63:32];
        win_r[j+4] <= key_long_r
                      ? ((j % 2 == 1) ? key_word_r[2+j/2][31:0] : key_word_r[2+j/2][63:32])
                      : ((j % 2 == 1) ? key_word_r[j/2][31:0] : key_word_r[j/2][63:32]);
      end
      idx_r <= key_long_r ? WordIdxW'(NkLong) : WordIdxW'(NkShort);
      rc_r  <= 8'h01;
    end else if (kx.step) begin
      rk_r[idx_r[5:0]] <= new_w;
      for (int j = 0; j < 7; j++) win_r[j] <= win_r[j+1];
      win_r[7] <= new_w;
      idx_r <= idx_r + WordIdxW'(1);
      if (nk_hit) rc_r <= xtime(rc_r);
    end
  end

  // round pipeline
  assign en        = !v_r[NumStages-1] || out_tready;
  assign in_tready = kx.ready && en;
  assign nr        = key_long_r ? 4'(RoundsLong) : 4'(RoundsShort);
  assign plain     = {in_tdata[63:0], in_tdata[127:64]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NumStages; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_tvalid && kx.ready;
      for (int s = 1; s < NumStages; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= plain ^ {rk_r[0], rk_r[1], rk_r[2], rk_r[3]};
      for (int s = 1; s < NumStages; s++) begin
        if (4'(s) > nr) begin
          st_r[s] <= st_r[s-1];
        end else begin
          st_r[s] <= aes_round(st_r[s-1],
                               {rk_r[4*s], rk_r[4*s+1], rk_r[4*s+2], rk_r[4*s+3]},
                               4'(s) != nr);
        end
      end
    end
  end

  assign out_tvalid = v_r[NumStages-1];
  assign out_tdata  = {st_r[NumStages-1][63:0], st_r[NumStages-1][127:64]};

`ifndef NO_ASSERTIONS
  a_in_needs_keys: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> kx_state_r == KX_DONE)
    else $error("request accepted before key expansion finished");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> kx_state_r == KX_LOAD)
    else $error("key write did not restart expansion");

  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    (kx_state_r == KX_RUN && $past(kx_state_r) == KX_LOAD) |-> idx_r < total)
    else $error("expansion index out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> !$past(in_tready))
    else $error("input accepted while output stalled");
`endif

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aes_pkg::*;

  localparam logic [2:0] CfgNoReg = 3'd7;
  localparam int unsigned CycleLimit = 600000;

  localparam logic [7:0] SubTab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // same layout as in_tdata / out_tdata: high half in the low bits
  typedef struct packed {
    logic [63:0] lo;
    logic [63:0] hi;
  } blk_t;

  typedef struct {
    blk_t plain;
    bit   known;
    blk_t cipher;
  } plain_req_t;

  typedef struct {
    logic [2:0]  idx;
    logic [63:0] data;
  } key_write_t;

  typedef struct {
    logic [63:0] k0, k1, k2, k3, klong;
  } key_set_t;

  typedef struct {
    int   set;
    blk_t plain;
    bit   known;
    blk_t cipher;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  aes_block_encrypt i_dut (.*);

  // predictor copy of the key registers and round keys
  logic [63:0] key_reg [4] = '{default: '0};
  logic        key_long_q = 1'b0;
  logic        keys_ready = 1'b0;
  logic [31:0] rk_word [60];

  plain_req_t  plain_q [$];
  blk_t        cipher_q [$];
  key_write_t  key_wr_q [$];
  int          errors = 0;
  int          cycles = 0;
  bit          no_gaps = 1'b0;
  bit          no_stalls = 1'b0;
  int          in_wait = 0;
  int          out_wait = 0;

  function automatic logic [7:0] xt(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_w(logic [31:0] w);
    return {SubTab[w[31:24]], SubTab[w[23:16]], SubTab[w[15:8]], SubTab[w[7:0]]};
  endfunction

  function automatic void expand_round_keys();
    int          nk;
    int          total;
    logic [31:0] t;
    logic [7:0]  rc;
    nk = key_long_q ? 8 : 4;
    total = key_long_q ? 60 : 44;
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      rk_word[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      t = rk_word[i-1];
      if (i % nk == 0) begin
        t = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = xt(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_w(t);
      end
      rk_word[i] = rk_word[i-nk] ^ t;
    end
    keys_ready = 1'b1;
  endfunction

  function automatic blk_t encrypt_block(blk_t p);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] all;
    int         nr;
    blk_t       c;
    if (!keys_ready) expand_round_keys();
    nr = key_long_q ? 14 : 10;
    for (int i = 0; i < 8; i++) begin
      s[i] = p.hi[63-8*i -: 8];
      s[8+i] = p.lo[63-8*i -: 8];
    end
    for (int r = 0; r <= nr; r++) begin
      if (r > 0) begin
        for (int cc = 0; cc < 4; cc++)
          for (int rr = 0; rr < 4; rr++)
            t[4*cc+rr] = SubTab[s[4*((cc+rr)%4)+rr]];
        for (int cc = 0; cc < 4; cc++) begin
          all = t[4*cc] ^ t[4*cc+1] ^ t[4*cc+2] ^ t[4*cc+3];
          for (int rr = 0; rr < 4; rr++)
            s[4*cc+rr] = (r == nr) ? t[4*cc+rr] :
                         t[4*cc+rr] ^ all ^ xt(t[4*cc+rr] ^ t[4*cc+(rr+1)%4]);
        end
      end
      for (int i = 0; i < 16; i++)
        s[i] ^= rk_word[4*r + i/4][31-8*(i%4) -: 8];
    end
    for (int i = 0; i < 8; i++) begin
      c.hi[63-8*i -: 8] = s[i];
      c.lo[63-8*i -: 8] = s[8+i];
    end
    return c;
  endfunction

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // plaintext source
  always @(posedge clk) begin
    plain_req_t rq;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        rq = plain_q.pop_front();
        cipher_q.insert(cipher_q.size(), rq.known ? rq.cipher : encrypt_block(rq.plain));
        if (rq.known) void'(encrypt_block(rq.plain));
        in_wait = no_gaps ? 0 : $urandom_range(0, 6);
      end
      if (in_tvalid && !in_tready) begin
      end else if (in_wait > 0) begin
        in_wait--;
        in_tvalid <= 1'b0;
      end else if (plain_q.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= plain_q[0].plain;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ciphertext sink and checker
  always @(posedge clk) begin
    blk_t got;
    blk_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (cipher_q.size() == 0) begin
          $display("%t: unexpected request %h", $realtime, got);
          errors++;
        end else begin
          want = cipher_q.pop_front();
          if (got.hi !== want.hi) begin
            $display("%t: cipher_high exp %h got %h", $realtime, want.hi, got.hi);
            errors++;
          end
          if (got.lo !== want.lo) begin
            $display("%t: cipher_low exp %h got %h", $realtime, want.lo, got.lo);
            errors++;
          end
        end
        out_wait = no_stalls ? 0 : $urandom_range(0, 6);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // key register writes
  always @(posedge clk) begin
    key_write_t w;
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        w = key_wr_q.pop_front();
        case (w.idx)
          CFG_KEY_WORD_0: key_reg[0] = w.data;
          CFG_KEY_WORD_1: key_reg[1] = w.data;
          CFG_KEY_WORD_2: key_reg[2] = w.data;
          CFG_KEY_WORD_3: key_reg[3] = w.data;
          CFG_KEY_LONG:   key_long_q = w.data[0];
          default: ;
        endcase
        if (w.idx <= CFG_KEY_LONG) keys_ready = 1'b0;
      end
      if (key_wr_q.size() > 0) begin
        cfg_valid <= 1'b1;
        cfg_index <= key_wr_q[0].idx;
        cfg_data <= key_wr_q[0].data;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  task automatic wait_drained();
    while (plain_q.size() > 0 || cipher_q.size() > 0 || in_tvalid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_key(logic [2:0] idx, logic [63:0] data);
    key_write_t w;
    w.idx = idx;
    w.data = data;
    key_wr_q.insert(key_wr_q.size(), w);
  endtask

  task automatic load_key_set(key_set_t ks);
    wait_drained();
    write_key(CFG_KEY_WORD_0, ks.k0);
    write_key(CFG_KEY_WORD_1, ks.k1);
    write_key(CFG_KEY_WORD_2, ks.k2);
    write_key(CFG_KEY_WORD_3, ks.k3);
    write_key(CFG_KEY_LONG, ks.klong);
    write_key(CfgNoReg, {$urandom, $urandom});
    while (key_wr_q.size() > 0 || cfg_valid) @(posedge clk);
  endtask

  task automatic push_plain(blk_t p, bit known, blk_t c);
    plain_req_t rq;
    rq.plain = p;
    rq.known = known;
    rq.cipher = c;
    plain_q.insert(plain_q.size(), rq);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  localparam logic [127:0] Zero = '0;
  localparam logic [127:0] Ones = '1;
  localparam logic [127:0] FipsPt = {64'h8899aabbccddeeff, 64'h0011223344556677};

  key_set_t key_sets [6];
  row_t     rows [$];

  initial begin
    key_set_t ks;
    int       cur;
    blk_t     nil;
    nil = '0;
    key_sets[0] = '{'0, '0, '0, '0, '0};
    key_sets[1] = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, '0, '0, 64'h0};
    key_sets[2] = '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                    64'h1011121314151617, 64'h18191a1b1c1d1e1f, 64'hfffffffffffffff1};
    key_sets[3] = '{'1, '1, '1, '1, 64'h1};
    key_sets[4] = '{'1, '1, 64'h0123456789abcdef, 64'hfedcba9876543210, 64'hfffffffffffffffe};
    key_sets[5] = '{'0, '0, '0, '0, 64'h1};
    rows = '{
      '{0, Zero, 1, {64'h884cfa59ca342b2e, 64'h66e94bd4ef8a2c3b}},
      '{0, Ones, 0, nil},
      '{0, {64'h0, 64'h8000000000000000}, 0, nil},
      '{0, {64'h1, 64'h0}, 0, nil},
      '{1, FipsPt, 1, {64'hd8cdb78070b4c55a, 64'h69c4e0d86a7b0430}},
      '{1, Zero, 0, nil},
      '{1, Ones, 0, nil},
      '{2, FipsPt, 1, {64'heafc49904b496089, 64'h8ea2b7ca516745bf}},
      '{2, Zero, 0, nil},
      '{2, Ones, 0, nil},
      '{3, Ones, 0, nil},
      '{3, Zero, 0, nil},
      '{4, Ones, 0, nil},
      '{4, Zero, 0, nil},
      '{5, Zero, 1, {64'had48a21492842087, 64'hdc95c078a2408989}},
      '{5, FipsPt, 0, nil}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    cur = 0;
    foreach (rows[i]) begin
      if (rows[i].set != cur) begin
        cur = rows[i].set;
        load_key_set(key_sets[cur]);
      end
      push_plain(rows[i].plain, rows[i].known, rows[i].cipher);
    end

    for (int ph = 0; ph < 10; ph++) begin
      wait_drained();
      if (ph % 3 == 0) begin
        ks = '{rand64(), rand64(), rand64(), rand64(), {$urandom, $urandom}};
        load_key_set(ks);
      end else begin
        // partial rewrite: only some registers change
        if ($urandom_range(0, 1)) write_key(CFG_KEY_WORD_0, rand64());
        if ($urandom_range(0, 1)) write_key(CFG_KEY_WORD_2, rand64());
        if ($urandom_range(0, 1)) write_key(CFG_KEY_WORD_3, rand64());
        write_key(CFG_KEY_WORD_1, rand64());
        if ($urandom_range(0, 2) == 0) write_key(CFG_KEY_LONG, {$urandom, $urandom});
        while (key_wr_q.size() > 0 || cfg_valid) @(posedge clk);
      end
      no_gaps = (ph % 4 == 1);
      no_stalls = (ph % 4 == 2);
      for (int n = 0; n < 125; n++) begin
        push_plain({rand64(), rand64()}, 1'b0, nil);
        if (n % 25 == 24) while (plain_q.size() > 8) @(posedge clk);
      end
    end

    no_gaps = 1'b0;
    no_stalls = 1'b0;
    while (plain_q.size() > 0 || cipher_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && cipher_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/aes_pkg.sv
rtl/core/aes_block_encrypt.sv
bench/tb.sv
